/* design/qurs_pkg.sv */
`timescale 1ns / 1ps
package qurs_pkg;

  localparam int TAG_W   = 32;
  localparam int TRAIN_W = 3;
  localparam int COUNT_W = 8;

  typedef struct packed {
    logic [TRAIN_W-1:0] train;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ENQUEUE = 2'd0;
  localparam kind_t KIND_PROCESS = 2'd1;
  localparam kind_t KIND_UNDO    = 2'd2;
  localparam kind_t KIND_REDO    = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t STATUS_OK            = 3'd0;
  localparam status_t STATUS_BAD_TRAIN     = 3'd1;
  localparam status_t STATUS_QUEUE_FULL    = 3'd2;
  localparam status_t STATUS_QUEUE_EMPTY   = 3'd3;
  localparam status_t STATUS_NO_HISTORY    = 3'd4;
  localparam status_t STATUS_NO_REDO       = 3'd5;
  localparam status_t STATUS_NOT_REQUEUED  = 3'd6;

  localparam logic [TRAIN_W-1:0] TRAIN_COUNT_RESET = 3'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

/* design/queue_with_undo_redo_stacks_top.sv */
`timescale 1ns / 1ps
// Ticket queue with undo and redo stacks.
// Command channel: cmd_valid / cmd_stall carry one word (kind, passenger_tag,
// train_choice): enqueue, process head, undo or redo.
// Response channel: rsp_valid / rsp_stall carry one word per command: status,
// the moved entry and the queue, history and redo occupancy after the command.
// cfg_write_en / cfg_write_data set train_count; write only while idle.
// Each command passes through ST_IDLE and ST_EXEC: the accept edge loads the
// registered read ports of the three entry memories, and in ST_EXEC the block
// does the read-modify-write and loads the response register. A new command
// is taken in the cycle after that, so a command is not accepted before the
// last one is through. The response register lets the next command be
// accepted while the previous response still waits.
// If rsp_stall holds a response and a second command is done, the block waits
// in its execute cycle until the response is taken.
// Reset (rst, synchronous) empties the queue and both stacks and sets
// train_count to 3; memory contents are not cleared.
module queue_with_undo_redo_stacks_top
  import qurs_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [TRAIN_W-1:0]   cfg_write_data,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [1:0]           kind,
  input  logic [TAG_W-1:0]     passenger_tag,
  input  logic [TRAIN_W-1:0]   train_choice,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [2:0]           status,
  output logic [TAG_W-1:0]     moved_tag,
  output logic [TRAIN_W-1:0]   moved_train,
  output logic [COUNT_W-1:0]   queue_count,
  output logic [COUNT_W-1:0]   history_count,
  output logic [COUNT_W-1:0]   redo_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] FULL_MARK = PW'(DEPTH);
  localparam logic [PW-1:0] ONE = PW'(1);

  state_t state, state_next;
  logic   cmd_accept;
  logic   exec_go;

  logic [TRAIN_W-1:0] train_count;

  kind_t              cmd_kind;
  logic [TAG_W-1:0]   cmd_tag;
  logic [TRAIN_W-1:0] cmd_train;

  logic [PW-1:0] queue_head, queue_tail, history_top, redo_top;
  logic [PW-1:0] queue_head_next, queue_tail_next, history_top_next, redo_top_next;

  entry_t queue_mem   [DEPTH];
  entry_t history_mem [DEPTH];
  entry_t redo_mem    [DEPTH];
  entry_t queue_rdata, history_rdata, redo_rdata;

  logic          queue_we, history_we, redo_we;
  logic [AW-1:0] queue_waddr, history_waddr, redo_waddr;
  entry_t        queue_wdata, history_wdata, redo_wdata;
  logic [AW-1:0] history_raddr, redo_raddr;

  status_t       status_next;
  entry_t        moved_next;
  logic [PW-1:0] queue_fill_next;

  // Control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = (state != ST_IDLE);
    exec_go   = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);
  end

  assign cmd_accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      train_count <= TRAIN_COUNT_RESET;
    end else if (cfg_write_en) begin
      train_count <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      cmd_kind  <= kind;
      cmd_tag   <= passenger_tag;
      cmd_train <= train_choice;
    end
  end

  // Memories: read ports follow the pointers every cycle
  assign history_raddr = AW'(history_top - ONE);
  assign redo_raddr    = AW'(redo_top - ONE);

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
    queue_rdata <= queue_mem[queue_head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (history_we) history_mem[history_waddr] <= history_wdata;
    history_rdata <= history_mem[history_raddr];
  end

  always_ff @(posedge clk) begin
    if (redo_we) redo_mem[redo_waddr] <= redo_wdata;
    redo_rdata <= redo_mem[redo_raddr];
  end

  // Execute step
  always_comb begin
    queue_head_next  = queue_head;
    queue_tail_next  = queue_tail;
    history_top_next = history_top;
    redo_top_next    = redo_top;
    status_next      = STATUS_OK;
    moved_next       = '0;
    queue_we         = 1'b0;
    history_we       = 1'b0;
    redo_we          = 1'b0;
    queue_waddr      = queue_tail[AW-1:0];
    history_waddr    = history_top[AW-1:0];
    redo_waddr       = redo_top[AW-1:0];
    queue_wdata      = '0;
    history_wdata    = '0;
    redo_wdata       = '0;

    unique case (cmd_kind)
      KIND_ENQUEUE: begin
        if (cmd_train == '0 || cmd_train > train_count) begin
          status_next = STATUS_BAD_TRAIN;
        end else if (queue_tail >= FULL_MARK) begin
          status_next = STATUS_QUEUE_FULL;
        end else begin
          moved_next.tag   = cmd_tag;
          moved_next.train = cmd_train;
          queue_we         = exec_go;
          queue_wdata      = moved_next;
          queue_tail_next  = queue_tail + ONE;
        end
      end
      KIND_PROCESS: begin
        if (queue_head >= queue_tail) begin
          status_next = STATUS_QUEUE_EMPTY;
        end else begin
          moved_next = queue_rdata;
          if (queue_head + ONE >= queue_tail) begin
            // queue drained: restart at zero
            queue_head_next = '0;
            queue_tail_next = '0;
          end else begin
            queue_head_next = queue_head + ONE;
          end
          if (history_top < FULL_MARK) begin
            history_we       = exec_go;
            history_wdata    = queue_rdata;
            history_top_next = history_top + ONE;
          end
          redo_top_next = '0;
        end
      end
      KIND_UNDO: begin
        if (history_top == '0) begin
          status_next = STATUS_NO_HISTORY;
        end else begin
          moved_next       = history_rdata;
          history_top_next = history_top - ONE;
          if (redo_top < FULL_MARK) begin
            redo_we       = exec_go;
            redo_wdata    = history_rdata;
            redo_top_next = redo_top + ONE;
          end
          if (queue_tail < FULL_MARK) begin
            queue_we        = exec_go;
            queue_wdata     = history_rdata;
            queue_tail_next = queue_tail + ONE;
          end else begin
            status_next = STATUS_NOT_REQUEUED;
          end
        end
      end
      KIND_REDO: begin
        if (redo_top == '0) begin
          status_next = STATUS_NO_REDO;
        end else begin
          moved_next    = redo_rdata;
          redo_top_next = redo_top - ONE;
          // history is never full here: redo entries came off it
          if (history_top < FULL_MARK) begin
            history_we       = exec_go;
            history_wdata    = redo_rdata;
            history_top_next = history_top + ONE;
          end
        end
      end
      default: status_next = STATUS_OK;
    endcase

    queue_fill_next = queue_tail_next - queue_head_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head  <= '0;
      queue_tail  <= '0;
      history_top <= '0;
      redo_top    <= '0;
    end else if (exec_go) begin
      queue_head  <= queue_head_next;
      queue_tail  <= queue_tail_next;
      history_top <= history_top_next;
      redo_top    <= redo_top_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status        <= status_next;
      moved_tag     <= moved_next.tag;
      moved_train   <= moved_next.train;
      queue_count   <= COUNT_W'(queue_fill_next);
      history_count <= COUNT_W'(history_top_next);
      redo_count    <= COUNT_W'(redo_top_next);
    end
  end

endmodule
